// ===== sv/trws_pkg.sv =====
`timescale 1ns / 1ps

package trws_pkg;

  // Event store geometry
  localparam int EVENT_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(EVENT_DEPTH);
  localparam int LEFT_W      = $clog2(EVENT_DEPTH + 1);

  // Per-tick write limit and result buffer geometry
  localparam int MAX_WRITES_PER_TICK = 63;
  localparam int CNT_W               = $clog2(MAX_WRITES_PER_TICK + 1);
  localparam int BUF_DEPTH           = 2 ** CNT_W;

  localparam int NEAR_END_EVENTS = 10;

  // Field widths
  localparam int TICK_W      = 32;
  localparam int INDEX_W     = 10;
  localparam int REG_W       = 8;
  localparam int VAL_W       = 8;
  localparam int DELAY_W     = 16;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 1;

  // Operation codes carried on s_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PLAY_ENABLE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SONG_EVENTS = 1'b1;

  // One stored event
  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic [VAL_W-1:0]   value;
    logic [REG_W-1:0]   register_addr;
  } event_t;

  // One buffered result
  typedef struct packed {
    logic             write_valid;
    logic [VAL_W-1:0] value;
    logic [REG_W-1:0] register_addr;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic load_event;
    logic start_tick;
    logic walk;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic play;
    logic due;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/trws_ctrl.sv =====
`timescale 1ns / 1ps

module trws_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_op,
  output logic            in_ready,
  input  trws_pkg::sts_t  sts,
  output trws_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == trws_pkg::OP_LOAD) begin
            cmd.load_event = 1'b1;
          end else if (sts.play) begin
            cmd.start_tick = 1'b1;
            state_next     = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (!sts.due) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/trws_dp.sv =====
`timescale 1ns / 1ps

module trws_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [trws_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [trws_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [trws_pkg::IN_TDATA_W-1:0]        in_data,
  input  trws_pkg::cmd_t                         cmd,
  output trws_pkg::sts_t                         sts,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic [trws_pkg::OUT_TDATA_W-1:0]       out_data,
  output logic                                   out_user,
  output logic                                   out_last
);

  // Playback state
  logic                              play_enable;
  logic [trws_pkg::LEFT_W-1:0]       song_events;
  logic [trws_pkg::ADDR_W-1:0]       read_position;
  logic [trws_pkg::ADDR_W-1:0]       read_position_next;
  logic [trws_pkg::LEFT_W-1:0]       events_left;
  logic [trws_pkg::TICK_W-1:0]       tick_count;
  logic [trws_pkg::TICK_W-1:0]       next_due_tick;
  logic                              near;

  // Per-tick bookkeeping
  logic [trws_pkg::CNT_W-1:0]        write_count;
  logic [trws_pkg::CNT_W-1:0]        emit_idx;

  // Memories
  trws_pkg::event_t                  event_store [trws_pkg::EVENT_DEPTH];
  trws_pkg::event_t                  rd_event;
  trws_pkg::result_t                 res_buf [trws_pkg::BUF_DEPTH];
  trws_pkg::result_t                 out_entry;
  logic                              out_near;

  // Input fields
  logic [trws_pkg::INDEX_W-1:0]      in_index;
  trws_pkg::event_t                  in_event;

  logic restart_cfg;
  logic step;
  logic finish;
  logic song_done;
  trws_pkg::result_t                 step_result;

  assign in_index               = in_data[9:0];
  assign in_event.register_addr = in_data[17:10];
  assign in_event.value         = in_data[25:18];
  assign in_event.delay         = in_data[41:26];

  assign restart_cfg = cfg_we && (cfg_index == trws_pkg::CFG_PLAY_ENABLE);
  assign step        = cmd.walk && sts.due;
  assign finish      = cmd.walk && !sts.due;
  assign song_done   = (events_left == '0);

  assign step_result.write_valid   = 1'b1;
  assign step_result.value         = rd_event.value;
  assign step_result.register_addr = rd_event.register_addr;

  // Report status
  assign sts.play      = play_enable;
  assign sts.due       = !song_done && (next_due_tick <= tick_count) &&
                         (write_count != trws_pkg::CNT_W'(trws_pkg::MAX_WRITES_PER_TICK));
  assign sts.emit_last = (emit_idx == write_count - trws_pkg::CNT_W'(1));
  assign sts.out_free  = !out_valid || out_ready;

  // Pick the next read position; the store read follows it
  always_comb begin
    read_position_next = read_position;
    if (restart_cfg) begin
      read_position_next = '0;
    end else if (step) begin
      read_position_next = read_position + trws_pkg::ADDR_W'(1);
    end else if (finish && song_done) begin
      read_position_next = '0;
    end
  end

  // Event store: load writes, prefetch read of the next event
  always_ff @(posedge clk) begin
    if (cmd.load_event) begin
      event_store[trws_pkg::ADDR_W'(in_index)] <= in_event;
    end
    rd_event <= event_store[read_position_next];
  end

  // Result buffer: walk writes, emit reads into the output register
  always_ff @(posedge clk) begin
    if (step) begin
      res_buf[write_count] <= step_result;
    end else if (finish && (write_count == '0)) begin
      res_buf[0] <= '0;
    end
    if (cmd.emit) begin
      out_entry <= res_buf[emit_idx];
      out_near  <= near;
      out_last  <= sts.emit_last;
    end
  end

  // Configuration and playback registers
  always_ff @(posedge clk) begin
    if (rst) begin
      play_enable   <= 1'b0;
      song_events   <= '0;
      read_position <= '0;
      events_left   <= '0;
      tick_count    <= '0;
      next_due_tick <= '0;
      near          <= 1'b0;
      write_count   <= '0;
      emit_idx      <= '0;
    end else begin
      read_position <= read_position_next;
      if (cfg_we) begin
        unique case (cfg_index)
          trws_pkg::CFG_PLAY_ENABLE: begin
            play_enable   <= cfg_data[0];
            events_left   <= song_events;
            tick_count    <= '0;
            next_due_tick <= '0;
          end
          trws_pkg::CFG_SONG_EVENTS: begin
            if (32'(cfg_data) > 32'(trws_pkg::EVENT_DEPTH)) begin
              song_events <= trws_pkg::LEFT_W'(trws_pkg::EVENT_DEPTH);
            end else begin
              song_events <= trws_pkg::LEFT_W'(cfg_data);
            end
          end
          default: ;
        endcase
      end
      // Start a tick
      if (cmd.start_tick) begin
        write_count <= '0;
        emit_idx    <= '0;
      end
      // Advance over one due event
      if (step) begin
        next_due_tick <= tick_count + trws_pkg::TICK_W'(rd_event.delay);
        events_left   <= events_left - trws_pkg::LEFT_W'(1);
        write_count   <= write_count + trws_pkg::CNT_W'(1);
      end
      // Close the tick, wrap at song end
      if (finish) begin
        near <= (events_left <= trws_pkg::LEFT_W'(trws_pkg::NEAR_END_EVENTS));
        if (write_count == '0) begin
          write_count <= trws_pkg::CNT_W'(1);
        end
        if (song_done) begin
          events_left   <= song_events;
          tick_count    <= '0;
          next_due_tick <= '0;
        end else begin
          tick_count <= tick_count + trws_pkg::TICK_W'(1);
        end
      end
      if (cmd.emit) begin
        emit_idx <= emit_idx + trws_pkg::CNT_W'(1);
      end
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_user = out_entry.write_valid;
  assign out_data = {7'b0, out_near, out_entry.value, out_entry.register_addr};

endmodule

// ===== sv/timed_register_write_sequencer.sv =====
`timescale 1ns / 1ps

// Plays a looping song of timed synthesizer register writes. Load items
// (s_tuser low) write one event into the store. A tick item (s_tuser
// high) while playing walks the due events one per cycle through the event
// store, at most 63 per tick, then sends the results one per cycle from a
// result buffer while m_tready stays high; a tick with no due event sends
// one result without a write. The next item is taken once the last result
// of a tick sits in the output register. A tick while not playing gives no
// result. Writing play_enable restarts the song from its first event;
// song_events takes effect at that write or at the next song wrap.
module timed_register_write_sequencer (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration
  input  logic                                 cfg_we,
  input  logic [trws_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [trws_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // event_index[9:0], load_register[17:10], load_value[25:18],
  // load_delay[41:26], zero fill[47:42]
  input  logic [trws_pkg::IN_TDATA_W-1:0]      s_tdata,
  // operation[0]
  input  logic                                 s_tuser,
  // Output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // write_register[7:0], write_value[15:8], near_end[16], zero fill[23:17]
  output logic [trws_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // write_valid[0]
  output logic                                 m_tuser,
  output logic                                 m_tlast
);

  trws_pkg::cmd_t cmd;
  trws_pkg::sts_t sts;

  trws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  trws_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_user  (m_tuser),
    .out_last  (m_tlast)
  );

`ifndef NO_ASSERTIONS
  // A result without a write is the only result of its tick and carries zeros
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata[15:0] == '0)))
    else $error("empty result not alone or not cleared");

  // A new transaction is taken only after the current tick is fully queued
  a_accept_after_tick: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> (!m_tvalid || m_tlast))
    else $error("input taken while a tick is still being sent");

  // Results of one tick follow back to back with the same near-end flag
  a_near_end_steady: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && (m_tdata[16] == $past(m_tdata[16]))))
    else $error("near-end flag changed within a tick");
`endif

endmodule

// ===== bench/timed_register_write_sequencer_tb.sv =====
`timescale 1ns / 1ps

module timed_register_write_sequencer_tb;

  localparam int LIMIT_CYCLES = 2_000_000;
  // Low part of the store that gets loaded; the random songs stay inside it
  localparam int FILL_EVENTS  = 128;

  // One result transaction as seen on the output stream
  typedef struct packed {
    logic                       write_valid;
    logic [trws_pkg::REG_W-1:0] write_register;
    logic [trws_pkg::VAL_W-1:0] write_value;
    logic                       near_end;
    logic                       last;
  } write_result_t;

  // Mirrors the song player and holds the writes each tick should produce
  class song_writes_tracker;
    trws_pkg::event_t                store [trws_pkg::EVENT_DEPTH];
    bit                              playing;
    bit [trws_pkg::LEFT_W-1:0]       song_len;
    bit [trws_pkg::LEFT_W-1:0]       events_left;
    bit [trws_pkg::ADDR_W-1:0]       read_pos;
    bit [trws_pkg::TICK_W-1:0]       tick_count;
    bit [trws_pkg::TICK_W-1:0]       next_due;
    write_result_t                   due_writes[$];
    int                              errors;
    int                              loads;
    int                              ticks;
    int                              stopped_ticks;
    int                              writes;
    int                              wraps;

    function void restart();
      read_pos    = '0;
      events_left = song_len;
      tick_count  = '0;
      next_due    = '0;
    endfunction

    function void note_config(logic [trws_pkg::CFG_INDEX_W-1:0] idx,
                              logic [trws_pkg::CFG_DATA_W-1:0] value);
      if (idx == trws_pkg::CFG_PLAY_ENABLE) begin
        playing = value[0];
        restart();
      end else if (idx == trws_pkg::CFG_SONG_EVENTS) begin
        // clamp to the store depth
        song_len = (value > trws_pkg::EVENT_DEPTH) ?
                   trws_pkg::LEFT_W'(trws_pkg::EVENT_DEPTH) : trws_pkg::LEFT_W'(value);
      end
    endfunction

    function void note_item(logic op, logic [trws_pkg::IN_TDATA_W-1:0] data);
      write_result_t    batch[$];
      write_result_t    r;
      trws_pkg::event_t e;
      bit               near;
      if (op == trws_pkg::OP_LOAD) begin
        store[data[9:0]] = '{delay: data[41:26], value: data[25:18],
                             register_addr: data[17:10]};
        loads++;
        return;
      end
      if (!playing) begin
        stopped_ticks++;
        return;
      end
      ticks++;
      // emit every due event, deferring the excess to the next tick
      while (events_left != 0 && next_due <= tick_count &&
             batch.size() < trws_pkg::MAX_WRITES_PER_TICK) begin
        e        = store[read_pos];
        next_due = tick_count + trws_pkg::TICK_W'(e.delay);
        r        = '{1'b1, e.register_addr, e.value, 1'b0, 1'b0};
        batch.push_back(r);
        read_pos++;
        events_left--;
      end
      writes += batch.size();
      tick_count++;
      near = (events_left <= trws_pkg::NEAR_END_EVENTS);
      if (events_left == 0) begin
        restart();
        wraps++;
      end
      if (batch.size() == 0) batch.push_back('0);
      foreach (batch[k]) begin
        batch[k].near_end = near;
        batch[k].last     = (k == batch.size() - 1);
        due_writes.push_back(batch[k]);
      end
    endfunction

    function void check_write(logic valid, logic [trws_pkg::REG_W-1:0] addr,
                              logic [trws_pkg::VAL_W-1:0] value,
                              logic near, logic last_flag);
      write_result_t exp;
      if (due_writes.size() == 0) begin
        $error("unexpected result transaction: no write pending");
        errors++;
        return;
      end
      exp = due_writes.pop_front();
      if (valid !== exp.write_valid) begin
        $error("write_valid: expected %0d, got %0d", exp.write_valid, valid);
        errors++;
      end
      if (addr !== exp.write_register) begin
        $error("write_register: expected %0d, got %0d", exp.write_register, addr);
        errors++;
      end
      if (value !== exp.write_value) begin
        $error("write_value: expected %0d, got %0d", exp.write_value, value);
        errors++;
      end
      if (near !== exp.near_end) begin
        $error("near_end: expected %0d, got %0d", exp.near_end, near);
        errors++;
      end
      if (last_flag !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, last_flag);
        errors++;
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst       = 1'b1;
  logic                             cfg_we    = 1'b0;
  logic [trws_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [trws_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                             s_tvalid  = 1'b0;
  logic                             s_tready;
  logic [trws_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                             s_tuser   = trws_pkg::OP_LOAD;
  logic                             m_tvalid;
  logic                             m_tready  = 1'b0;
  logic [trws_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tuser;
  logic                             m_tlast;

  song_writes_tracker song = new();
  int gap_pct;
  int stall_pct;
  int cycle_count;

  timed_register_write_sequencer i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall the output side at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Check every accepted result transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      song.check_write(m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[16], m_tlast);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d writes still pending",
               cycle_count, song.due_writes.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one item, idling at random first; returns at the falling edge after acceptance
  task automatic send_item(input logic op, input logic [trws_pkg::IN_TDATA_W-1:0] data);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    song.note_item(op, data);
    @(negedge clk);
  endtask

  task automatic send_load(input int idx, input logic [trws_pkg::REG_W-1:0] addr,
                           input logic [trws_pkg::VAL_W-1:0] value,
                           input logic [trws_pkg::DELAY_W-1:0] delay);
    send_item(trws_pkg::OP_LOAD, {6'b0, delay, value, addr, idx[trws_pkg::INDEX_W-1:0]});
  endtask

  task automatic send_tick();
    send_item(trws_pkg::OP_TICK, trws_pkg::IN_TDATA_W'({$urandom, $urandom}));
  endtask

  // Hold the input side idle until every expected write has arrived, then settle
  task automatic wait_drained(input int settle);
    s_tvalid <= 1'b0;
    while (song.due_writes.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [trws_pkg::CFG_INDEX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[trws_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    song.note_config(idx, value[trws_pkg::CFG_DATA_W-1:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Pick a song length and play state, then mix ticks with loads
  task automatic run_song_phase(input int items);
    int r;
    int len;
    int idx;
    int d;
    logic [trws_pkg::DELAY_W-1:0] delay;
    wait_drained(16);
    r = $urandom_range(0, 9);
    if (r == 0)      len = 0;
    else if (r == 1) len = 1;
    else if (r <= 6) len = $urandom_range(2, 30);
    else             len = $urandom_range(31, FILL_EVENTS);
    write_reg(trws_pkg::CFG_SONG_EVENTS, len);
    write_reg(trws_pkg::CFG_PLAY_ENABLE, int'($urandom_range(0, 7) != 0));
    repeat (items) begin
      if ($urandom_range(0, 3) == 0) begin
        // favor the start of the store, where short songs play
        idx = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 31) :
                                             $urandom_range(0, FILL_EVENTS - 1);
        d = $urandom_range(0, 99);
        if (d < 50)      delay = '0;
        else if (d < 80) delay = trws_pkg::DELAY_W'($urandom_range(1, 3));
        else if (d < 95) delay = trws_pkg::DELAY_W'($urandom_range(4, 20));
        else             delay = trws_pkg::DELAY_W'($urandom_range(0, 65535));
        send_load(idx, trws_pkg::REG_W'($urandom), trws_pkg::VAL_W'($urandom), delay);
      end else begin
        send_tick();
      end
    end
  endtask

  initial begin
    int w0;
    gap_pct   = 0;
    stall_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Stopped player, field extremes, empty song
    write_reg(trws_pkg::CFG_SONG_EVENTS, 0);
    write_reg(trws_pkg::CFG_PLAY_ENABLE, 0);
    send_tick();
    send_load(0, 8'h00, 8'h00, 16'h0000);
    send_load(1, 8'hFF, 8'hFF, 16'h0001);
    send_load(2, 8'h5A, 8'hA5, 16'h0000);
    send_load(3, 8'h12, 8'h34, 16'hFFFF);
    send_load(1023, 8'hFF, 8'h00, 16'hFFFF);
    wait_drained(16);
    write_reg(trws_pkg::CFG_PLAY_ENABLE, 1);
    send_tick();
    send_tick();

    // Four-event song: due timing, wrap, and a load while playing
    wait_drained(16);
    write_reg(trws_pkg::CFG_SONG_EVENTS, 4);
    write_reg(trws_pkg::CFG_PLAY_ENABLE, 1);
    send_tick();
    send_tick();
    send_tick();
    send_load(2, 8'hC3, 8'h3C, 16'h0002);
    send_tick();
    send_tick();
    wait_drained(16);
    write_reg(trws_pkg::CFG_PLAY_ENABLE, 0);
    send_tick();

    // Fill the low part of the store, mostly with zero delays so ticks overflow
    wait_drained(16);
    gap_pct   = 25;
    stall_pct = 25;
    for (int i = 0; i < FILL_EVENTS; i++)
      send_load(i, trws_pkg::REG_W'($urandom), trws_pkg::VAL_W'($urandom),
                ($urandom_range(0, 99) < 3) ? 16'd1 : 16'd0);

    // Play one full pass over the filled events, overflowing ticks included
    wait_drained(16);
    write_reg(trws_pkg::CFG_SONG_EVENTS, FILL_EVENTS);
    write_reg(trws_pkg::CFG_PLAY_ENABLE, 1);
    w0 = song.wraps;
    while (song.wraps == w0) send_tick();

    // Oversized length clamps to the full store; two ticks stay in the filled part
    wait_drained(16);
    write_reg(trws_pkg::CFG_SONG_EVENTS, 2047);
    write_reg(trws_pkg::CFG_PLAY_ENABLE, 1);
    send_tick();
    send_tick();

    // Random songs under each idle pattern
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 60; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 60; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      repeat (2) run_song_phase(18);
    end

    wait_drained(150);
    if (song.due_writes.size() != 0) begin
      $error("%0d expected writes never arrived", song.due_writes.size());
      song.errors++;
    end
    $display("Covered %0d loads, %0d playing ticks (%0d writes, %0d song wraps)",
             song.loads, song.ticks, song.writes, song.wraps);
    $display("and %0d ticks while stopped, across four idle patterns", song.stopped_ticks);
    if (song.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/trws_pkg.sv
sv/trws_ctrl.sv
sv/trws_dp.sv
sv/timed_register_write_sequencer.sv
bench/timed_register_write_sequencer_tb.sv
